/* rtl/core/dertlv_pkg.sv */
// Package for the DER TLV header parser: phase and status codes, the result
// record and the parser-to-buffer hand-off struct. No dependencies.
`timescale 1ns / 1ps

package dertlv_pkg;

    // Longest long-form length field accepted, in bytes
    localparam int unsigned MAX_LENGTH_BYTES = 4;

    // Identifier octet: low five bits all ones marks a multi-byte tag
    localparam logic [4:0] TAG_MULTI_MASK  = 5'h1F;
    localparam int unsigned CONSTRUCTED_BIT = 5;
    localparam int unsigned LONG_FORM_BIT   = 7;

    // Output beat: 76 bits of fields padded to 80
    localparam int unsigned TDATA_W = 80;

    typedef enum logic [2:0] {
        PH_TAG       = 3'd0,
        PH_LEN       = 3'd1,
        PH_LONG      = 3'd2,
        PH_CONTENT   = 3'd3,
        PH_END       = 3'd4,
        PH_ERR_TAG   = 3'd5,
        PH_ERR_LEN   = 3'd6,
        PH_ERR_TRUNC = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_HEADER    = 3'd0,
        ST_END       = 3'd1,
        ST_MULTI_TAG = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_TRUNC     = 3'd4
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  tag_byte;
        logic        constructed;
        logic [31:0] content_length;
        logic [2:0]  header_length;
        logic [31:0] value_offset;
        logic        last_of_run;
    } result_t;

    // Results raised by one byte: none, one or two
    typedef struct packed {
        logic        valid;
        logic [1:0]  n_res;
        result_t     res0;
        result_t     res1;
    } parse_out_t;

    // Status-only result record (fields other than status, offset and last_of_run are zero)
    function automatic result_t make_status(status_t st, logic [31:0] offset);
        result_t r;
        r                = '0;
        r.status         = st;
        r.value_offset   = offset;
        r.last_of_run    = 1'b1;
        return r;
    endfunction

    // Status repeated by a sticky phase
    function automatic status_t sticky_status(phase_t ph);
        status_t st;
        unique case (ph)
            PH_ERR_TAG:   st = ST_MULTI_TAG;
            PH_ERR_LEN:   st = ST_BAD_LEN;
            PH_ERR_TRUNC: st = ST_TRUNC;
            default:      st = ST_END;
        endcase
        return st;
    endfunction

endpackage

/* rtl/core/dertlv_parser.sv */
// Byte-at-a-time DER header parser: holds the parse state and works out the
// results of each accepted byte in one pass. Depends on dertlv_pkg.
`timescale 1ns / 1ps

module dertlv_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [31:0]           cfg_wdata,
    input  logic                  byte_valid,
    input  logic [7:0]            byte_data,
    output dertlv_pkg::parse_out_t pout
);

    dertlv_pkg::phase_t phase_reg, phase_next;
    logic [31:0] region_len_reg;
    logic [31:0] offset_reg, offset_next;
    logic [7:0]  tag_reg, tag_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  len_left_reg, len_left_next;
    logic [2:0]  hdr_seen_reg, hdr_seen_next;
    logic [31:0] content_left_reg, content_left_next;
    logic [31:0] vstart_reg, vstart_next;

    logic [31:0] offset_inc;
    logic [31:0] rem;
    logic [31:0] rem_after;
    logic [6:0]  lf_count;
    logic        hd_go;
    logic [31:0] hd_len;
    logic        vd_go;
    logic        vd_emit;
    dertlv_pkg::status_t vd_status;
    dertlv_pkg::phase_t  vd_phase;

    // Next state and results for the byte on the input
    always_comb
    begin
        phase_next        = phase_reg;
        offset_next       = offset_reg;
        tag_next          = tag_reg;
        acc_next          = acc_reg;
        len_left_next     = len_left_reg;
        hdr_seen_next     = hdr_seen_reg;
        content_left_next = content_left_reg;
        vstart_next       = vstart_reg;
        pout.valid        = byte_valid;
        pout.n_res        = 2'd0;
        pout.res0         = dertlv_pkg::make_status(dertlv_pkg::ST_END, vstart_reg);
        pout.res1         = dertlv_pkg::make_status(dertlv_pkg::ST_END, vstart_reg);
        hd_go             = 1'b0;
        hd_len            = '0;
        vd_go             = 1'b0;

        offset_inc = offset_reg + 32'd1;
        rem        = (offset_reg >= region_len_reg) ? '0 : region_len_reg - offset_reg;
        rem_after  = (rem == '0) ? '0 : rem - 32'd1;
        lf_count   = byte_data[6:0];

        // Region end check after a value finishes (offset already advanced)
        vd_emit   = (rem_after == 32'd0) || (rem_after == 32'd1);
        vd_status = (rem_after == 32'd0) ? dertlv_pkg::ST_END : dertlv_pkg::ST_TRUNC;
        vd_phase  = (rem_after == 32'd0) ? dertlv_pkg::PH_END : dertlv_pkg::PH_ERR_TRUNC;

        unique case (phase_reg)
            dertlv_pkg::PH_TAG:
            begin
                vstart_next = offset_reg;
                if (rem == 32'd0)
                begin
                    phase_next = dertlv_pkg::PH_END;
                    pout.n_res = 2'd1;
                    pout.res0  = dertlv_pkg::make_status(dertlv_pkg::ST_END, offset_reg);
                end
                else if (rem == 32'd1)
                begin
                    phase_next = dertlv_pkg::PH_ERR_TRUNC;
                    pout.n_res = 2'd1;
                    pout.res0  = dertlv_pkg::make_status(dertlv_pkg::ST_TRUNC, offset_reg);
                end
                else if (byte_data[4:0] == dertlv_pkg::TAG_MULTI_MASK)
                begin
                    phase_next = dertlv_pkg::PH_ERR_TAG;
                    pout.n_res = 2'd1;
                    pout.res0  = dertlv_pkg::make_status(dertlv_pkg::ST_MULTI_TAG,
                                                         offset_reg);
                end
                else
                begin
                    tag_next      = byte_data;
                    offset_next   = offset_inc;
                    hdr_seen_next = 3'd1;
                    phase_next    = dertlv_pkg::PH_LEN;
                end
            end
            dertlv_pkg::PH_LEN:
            begin
                offset_next   = offset_inc;
                hdr_seen_next = 3'd2;
                if (!byte_data[dertlv_pkg::LONG_FORM_BIT])
                begin
                    hd_go  = 1'b1;
                    hd_len = {24'd0, byte_data};
                end
                else if ((lf_count == 7'd0) ||
                         (lf_count > 7'(dertlv_pkg::MAX_LENGTH_BYTES)))
                begin
                    phase_next = dertlv_pkg::PH_ERR_LEN;
                    pout.n_res = 2'd1;
                    pout.res0  = dertlv_pkg::make_status(dertlv_pkg::ST_BAD_LEN, vstart_reg);
                end
                else if ({25'd0, lf_count} > rem_after)
                begin
                    phase_next = dertlv_pkg::PH_ERR_TRUNC;
                    pout.n_res = 2'd1;
                    pout.res0  = dertlv_pkg::make_status(dertlv_pkg::ST_TRUNC, vstart_reg);
                end
                else
                begin
                    acc_next      = '0;
                    len_left_next = lf_count[2:0];
                    phase_next    = dertlv_pkg::PH_LONG;
                end
            end
            dertlv_pkg::PH_LONG:
            begin
                acc_next      = {acc_reg[23:0], byte_data};
                offset_next   = offset_inc;
                hdr_seen_next = hdr_seen_reg + 3'd1;
                len_left_next = len_left_reg - 3'd1;
                if (len_left_next == 3'd0)
                begin
                    hd_go  = 1'b1;
                    hd_len = acc_next;
                end
            end
            dertlv_pkg::PH_CONTENT:
            begin
                offset_next       = offset_inc;
                content_left_next = content_left_reg - 32'd1;
                if (content_left_next == 32'd0)
                begin
                    vd_go = 1'b1;
                end
            end
            dertlv_pkg::PH_END, dertlv_pkg::PH_ERR_TAG,
            dertlv_pkg::PH_ERR_LEN, dertlv_pkg::PH_ERR_TRUNC:
            begin
                pout.n_res = 2'd1;
                pout.res0  = dertlv_pkg::make_status(
                                 dertlv_pkg::sticky_status(phase_reg), vstart_reg);
            end
        endcase

        // Header complete: report it, or flag truncation
        if (hd_go)
        begin
            if (hd_len > rem_after)
            begin
                phase_next = dertlv_pkg::PH_ERR_TRUNC;
                pout.n_res = 2'd1;
                pout.res0  = dertlv_pkg::make_status(dertlv_pkg::ST_TRUNC, vstart_reg);
            end
            else
            begin
                pout.n_res                = 2'd1;
                pout.res0.status          = dertlv_pkg::ST_HEADER;
                pout.res0.tag_byte        = tag_reg;
                pout.res0.constructed     = tag_reg[dertlv_pkg::CONSTRUCTED_BIT];
                pout.res0.content_length  = hd_len;
                pout.res0.header_length   = hdr_seen_next;
                pout.res0.value_offset    = vstart_reg;
                pout.res0.last_of_run     = 1'b1;
                content_left_next         = hd_len;
                if (hd_len == 32'd0)
                begin
                    // Empty content: value ends with its header
                    phase_next  = dertlv_pkg::PH_TAG;
                    vstart_next = offset_inc;
                    if (vd_emit)
                    begin
                        phase_next             = vd_phase;
                        pout.n_res             = 2'd2;
                        pout.res0.last_of_run  = 1'b0;
                        pout.res1 = dertlv_pkg::make_status(vd_status, offset_inc);
                    end
                end
                else
                begin
                    phase_next = dertlv_pkg::PH_CONTENT;
                end
            end
        end

        // Last content byte: back to tag, or report the region end
        if (vd_go)
        begin
            phase_next  = dertlv_pkg::PH_TAG;
            vstart_next = offset_inc;
            if (vd_emit)
            begin
                phase_next = vd_phase;
                pout.n_res = 2'd1;
                pout.res0  = dertlv_pkg::make_status(vd_status, offset_inc);
            end
        end
    end

    // Parse state; a region length write restarts at offset zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= dertlv_pkg::PH_TAG;
            region_len_reg   <= '0;
            offset_reg       <= '0;
            tag_reg          <= '0;
            acc_reg          <= '0;
            len_left_reg     <= '0;
            hdr_seen_reg     <= '0;
            content_left_reg <= '0;
            vstart_reg       <= '0;
        end
        else if (cfg_we)
        begin
            phase_reg        <= dertlv_pkg::PH_TAG;
            region_len_reg   <= cfg_wdata;
            offset_reg       <= '0;
            tag_reg          <= '0;
            acc_reg          <= '0;
            len_left_reg     <= '0;
            hdr_seen_reg     <= '0;
            content_left_reg <= '0;
            vstart_reg       <= '0;
        end
        else if (byte_valid)
        begin
            phase_reg        <= phase_next;
            offset_reg       <= offset_next;
            tag_reg          <= tag_next;
            acc_reg          <= acc_next;
            len_left_reg     <= len_left_next;
            hdr_seen_reg     <= hdr_seen_next;
            content_left_reg <= content_left_next;
            vstart_reg       <= vstart_next;
        end
    end

endmodule

/* rtl/core/dertlv_out_buf.sv */
// Four-entry result buffer: takes up to two results a cycle from the parser
// and hands them out one beat at a time. Depends on dertlv_pkg.
`timescale 1ns / 1ps

module dertlv_out_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dertlv_pkg::parse_out_t pin,
    output logic                   room,
    output logic                   out_valid,
    input  logic                   out_ready,
    output dertlv_pkg::result_t    out_res,
    output logic [2:0]             level
);

    dertlv_pkg::result_t entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [2:0] n_push;
    logic [1:0] wr_ptr_b;

    // Space for a worst-case byte (two results)
    assign room      = (count_reg <= 3'd2);
    assign out_valid = (count_reg != 3'd0);
    assign out_res   = entry_reg[rd_ptr_reg];
    assign level     = count_reg;

    assign pop      = out_valid && out_ready;
    assign n_push   = pin.valid ? {1'b0, pin.n_res} : 3'd0;
    assign wr_ptr_b = wr_ptr_reg + 2'd1;

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + n_push[1:0];
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + n_push - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (n_push != 3'd0)
        begin
            entry_reg[wr_ptr_reg] <= pin.res0;
        end
        if (n_push == 3'd2)
        begin
            entry_reg[wr_ptr_b] <= pin.res1;
        end
    end

endmodule

/* rtl/core/der_tlv_header_parser_unit.sv */
// DER TLV header parser, top level: byte stream in, header and status records out.
// Depends on dertlv_pkg, dertlv_parser and dertlv_out_buf.
`timescale 1ns / 1ps

// Usage
//   s_* : one region byte per beat, s_tdata[7:0].
//   m_* : one result per beat; tuser carries the status, tlast marks the last
//         result raised by one input byte.
//   cfg_we / cfg_wdata : region length; a write restarts parsing at offset 0.
//   Write it only while no result is pending.
// Timing
//   A byte is taken in every cycle while s_tready is high. Its results are
//   registered in a four-entry buffer and go out on m_* in order.
//   Most bytes raise no result; a header raises one, or two when the value
//   also closes the region. Sustained rate is one byte per cycle, bounded
//   only by the output side taking one result per cycle.
//   s_tready drops while fewer than two buffer entries are free, so a stalled
//   receiver holds the source off after at most three further result-bearing
//   bytes; nothing is lost.
// Reset
//   rst_n clears the parse state, the region length (to zero) and the buffer.
module der_tlv_header_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [dertlv_pkg::TDATA_W-1:0] m_tdata,
                                   // [7:0] tag_byte, [8] constructed,
                                   // [40:9] content_length, [43:41] header_length,
                                   // [75:44] value_offset, [79:76] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast    // last_of_run
);

    dertlv_pkg::parse_out_t pout;
    dertlv_pkg::result_t    head;
    logic                   accept;
    logic                   room;
    logic [2:0]             level;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    // Parse state and per-byte result generation
    dertlv_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_valid (accept),
        .byte_data  (s_tdata),
        .pout       (pout)
    );

    // Result buffer towards the output stream
    dertlv_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .pin       (pout),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (head),
        .level     (level)
    );

    // Output beat packing
    assign m_tdata = {4'd0, head.value_offset, head.header_length,
                      head.content_length, head.constructed, head.tag_byte};
    assign m_tuser = head.status;
    assign m_tlast = head.last_of_run;

`ifndef ASSERT_OFF
    // Buffer never overfills
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= 3'd4)
        else $error("result buffer overfilled");

    // Header records carry a header length of 2 to 6
    a_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == dertlv_pkg::ST_HEADER) |->
        (m_tdata[43:41] >= 3'd2 && m_tdata[43:41] <= 3'd6))
        else $error("header length out of range");

    // Status records carry no tag, length or header length
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != dertlv_pkg::ST_HEADER) |->
        (m_tdata[43:0] == 44'd0 && m_tlast))
        else $error("status record with header fields set");

    // A byte with no buffer room is never taken
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (level > 3'd2) |-> !accept)
        else $error("byte accepted without buffer room");
`endif

endmodule
